// ===== src/sdcs_pkg.sv =====
`default_nettype none
package sdcs_pkg;

  localparam logic [7:0] ADDR_MASK = 8'hE0;
  localparam int unsigned ADDR_SHIFT = 5;
  localparam int unsigned PULSE_SLOTS = 32;

  localparam logic [2:0] BCAST_ADDR = 3'b111;
  localparam logic [2:0] AP_MODULE_ADDR = 3'd2;

  localparam logic [3:0] BC_CLEAR_ALL = 4'd0;
  localparam logic [3:0] BC_NUMBER_MODE = 4'd1;
  localparam logic [3:0] BC_SEGMENT_MODE = 4'd2;
  localparam logic [3:0] BC_WRITE_A = 4'b1000;
  localparam logic [3:0] BC_WRITE_P = 4'b1001;

  localparam logic [7:0] A_SET_MASK = 8'b01110111;
  localparam logic [7:0] A_CLR_MASK = 8'b00001000;
  localparam logic [7:0] P_SET_MASK = 8'b01110011;
  localparam logic [7:0] P_CLR_MASK = 8'b10001100;

  localparam logic [2:0] PADDR_MODULE_ADDRESS = 3'd0;

  typedef logic [PULSE_SLOTS-1:0] pulse_vec_t;

  // one queued request: pulses in drain order, bit {set_clear, digit, segment}
  typedef struct packed {
    logic       valid;
    pulse_vec_t pulses;
  } pulse_req_t;

  function automatic logic [7:0] seg_pattern(input logic [3:0] data);
    logic [7:0] pat;
    case (data)
      4'h0: pat = 8'b00111111;
      4'h1: pat = 8'b00000011;
      4'h2: pat = 8'b01011011;
      4'h3: pat = 8'h4F;
      4'h4: pat = 8'h66;
      4'h5: pat = 8'h6D;
      4'h6: pat = 8'h7D;
      4'h7: pat = 8'h07;
      4'h8: pat = 8'h7F;
      4'h9: pat = 8'b01101111;
      4'hA: pat = 8'h01;
      4'hB: pat = 8'b00001000;
      4'hC: pat = 8'h40;
      4'hD: pat = 8'h09;
      4'hE: pat = 8'h48;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

// ===== src/segment_display_command_sequencer_core.sv =====
`default_nettype none
// channel   | handshake                    | payload
// command   | command_valid, command_stall | command_byte
// pulse     | pulse_valid, pulse_stall     | set_clear, digit_select, segment_index, last_pulse
// config    | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// a command is classified in the cycle it is taken and queued as a pulse list
// the drain unit gives one pulse per cycle while not stalled: 8 for a digit number,
// 1 in segment mode, 16 for clear-all, 7 for broadcast write A, 8 for write P;
// each request is fetched from the queue first; command_stall rises only when the
// queue is full; pulse_stall holds the output register and the drain unit behind it
// rst is synchronous: number mode, module address 0, queue and outputs empty
module segment_display_command_sequencer_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         command_valid,
  output logic        command_stall,
  input  wire  [7:0]  command_byte,
  output logic        pulse_valid,
  input  wire         pulse_stall,
  output logic        set_clear,
  output logic        digit_select,
  output logic [2:0]  segment_index,
  output logic        last_pulse,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                 [2:0] module_address;
  logic                       queue_full;
  logic                       pop;
  sdcs_pkg::pulse_req_t       push;
  sdcs_pkg::pulse_req_t       head;

  assign pready = 1'b1;
  assign prdata = (paddr == sdcs_pkg::PADDR_MODULE_ADDRESS) ? {29'b0, module_address} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      module_address <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr == sdcs_pkg::PADDR_MODULE_ADDRESS) begin
      module_address <= pwdata[2:0];
    end
  end

  sdcs_front u_front (
    .clk            (clk),
    .rst            (rst),
    .command_valid  (command_valid),
    .command_byte   (command_byte),
    .queue_full     (queue_full),
    .module_address (module_address),
    .command_stall  (command_stall),
    .push           (push)
  );

  sdcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (queue_full),
    .head (head)
  );

  sdcs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .pulse_valid   (pulse_valid),
    .pulse_stall   (pulse_stall),
    .set_clear     (set_clear),
    .digit_select  (digit_select),
    .segment_index (segment_index),
    .last_pulse    (last_pulse)
  );

endmodule
`default_nettype wire

// ===== src/sdcs_front.sv =====
`default_nettype none
module sdcs_front (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       command_valid,
  input  wire  [7:0]                command_byte,
  input  wire                       queue_full,
  input  wire  [2:0]                module_address,
  output logic                      command_stall,
  output sdcs_pkg::pulse_req_t      push
);

  logic                  segment_mode;
  logic                  segment_mode_next;
  logic                  accept;
  logic [2:0]            addr;
  logic                  dg;
  logic [3:0]            data;
  logic [7:0]            pattern;
  sdcs_pkg::pulse_vec_t  vec;

  assign command_stall = queue_full;
  assign accept = command_valid && !queue_full;

  assign addr = 3'((command_byte & sdcs_pkg::ADDR_MASK) >> sdcs_pkg::ADDR_SHIFT);
  assign dg = command_byte[4];
  assign data = command_byte[3:0];
  assign pattern = sdcs_pkg::seg_pattern(data);

  always_comb begin
    vec = '0;
    if (addr == module_address && addr != sdcs_pkg::BCAST_ADDR) begin
      if (!segment_mode) begin
        if (dg) begin
          vec[15:8] = ~pattern;
          vec[31:24] = pattern;
        end else begin
          vec[7:0] = ~pattern;
          vec[23:16] = pattern;
        end
      end else begin
        vec[{data[3], dg, data[2:0]}] = 1'b1;
      end
    end
    if (addr == sdcs_pkg::BCAST_ADDR) begin
      if (module_address == sdcs_pkg::AP_MODULE_ADDR) begin
        if (data == sdcs_pkg::BC_WRITE_P) begin
          vec[15:8] = sdcs_pkg::P_CLR_MASK;
          vec[31:24] = sdcs_pkg::P_SET_MASK;
        end else if (data == sdcs_pkg::BC_WRITE_A) begin
          vec[15:8] = sdcs_pkg::A_CLR_MASK;
          vec[31:24] = sdcs_pkg::A_SET_MASK;
        end
      end
      if (data == sdcs_pkg::BC_CLEAR_ALL) begin
        vec = '0;
        vec[15:0] = 16'hFFFF;
      end
    end
  end

  always_comb begin
    segment_mode_next = segment_mode;
    if (accept && addr == sdcs_pkg::BCAST_ADDR) begin
      if (data == sdcs_pkg::BC_NUMBER_MODE) begin
        segment_mode_next = 1'b0;
      end else if (data == sdcs_pkg::BC_SEGMENT_MODE) begin
        segment_mode_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_mode <= 1'b0;
    end else begin
      segment_mode <= segment_mode_next;
    end
  end

  assign push.valid = accept && (vec != '0);
  assign push.pulses = vec;

  // a command never drains more than sixteen pulses
  a_max_pulses: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> $countones(push.pulses) <= 16)
    else $error("front: more than sixteen pulses queued");

  a_mode_only_bcast: assert property (@(posedge clk) disable iff (rst)
    (segment_mode != $past(segment_mode)) |->
      $past(accept) && $past(addr) == sdcs_pkg::BCAST_ADDR)
    else $error("front: mode changed without broadcast");

endmodule
`default_nettype wire

// ===== src/sdcs_queue.sv =====
`default_nettype none
module sdcs_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire                       clk,
  input  wire                       rst,
  input  sdcs_pkg::pulse_req_t      push,
  input  wire                       pop,
  output logic                      full,
  output sdcs_pkg::pulse_req_t      head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  sdcs_pkg::pulse_vec_t entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full = (count == CW'(DEPTH));
  assign do_push = push.valid && !full;
  assign do_pop = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.pulses = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.pulses;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("queue: push while full");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue: count out of range");

endmodule
`default_nettype wire

// ===== src/sdcs_back.sv =====
`default_nettype none
module sdcs_back (
  input  wire                       clk,
  input  wire                       rst,
  input  sdcs_pkg::pulse_req_t      head,
  output logic                      pop,
  output logic                      pulse_valid,
  input  wire                       pulse_stall,
  output logic                      set_clear,
  output logic                      digit_select,
  output logic [2:0]                segment_index,
  output logic                      last_pulse
);

  sdcs_pkg::pulse_vec_t cur;
  sdcs_pkg::pulse_vec_t lowbit;
  sdcs_pkg::pulse_vec_t remaining;
  logic                 cur_valid;
  logic [4:0]           slot;
  logic                 load;

  assign pop = !cur_valid && head.valid;
  assign load = cur_valid && (!pulse_valid || !pulse_stall);

  assign lowbit = cur & (~cur + 1'b1);
  assign remaining = cur & (cur - 1'b1);

  always_comb begin
    slot = '0;
    for (int k = 0; k < sdcs_pkg::PULSE_SLOTS; k++) begin
      if (lowbit[k]) begin
        slot = slot | 5'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pulse_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (load && remaining == '0) begin
        cur_valid <= 1'b0;
      end
      if (load) begin
        pulse_valid <= 1'b1;
      end else if (!pulse_stall) begin
        pulse_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.pulses;
    end else if (load) begin
      cur <= remaining;
    end
    if (load) begin
      set_clear <= slot[4];
      digit_select <= slot[3];
      segment_index <= slot[2:0];
      last_pulse <= (remaining == '0);
    end
  end

  a_cur_nonempty: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> cur != '0)
    else $error("back: empty request held");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (load && remaining == '0) |=> !cur_valid)
    else $error("back: request continues after last pulse");

endmodule
`default_nettype wire
